// File: sv/minifloat_to_binary64_assert.svh
// Assertion macros for the minifloat to binary64 converter
`ifndef MINIFLOAT_TO_BINARY64_ASSERT_SVH
`define MINIFLOAT_TO_BINARY64_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define MF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define MF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/mf2d_pkg.sv
// Package: register map, widths and types for the minifloat converter
package mf2d_pkg;
    localparam int PATTERN_BITS_DEF = 32;
    localparam int TW_W = 6;
    localparam int EW_W = 4;
    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] ADDR_TOTAL_WIDTH = 3'd0;
    localparam logic [CFG_AW-1:0] ADDR_EXPONENT_WIDTH = 3'd4;
    localparam logic [TW_W-1:0] TW_RESET = 6'd16;
    localparam logic [EW_W-1:0] EW_RESET = 4'd5;

    // Decoded format settings after saturation
    typedef struct packed {
        logic [5:0] t;
        logic [3:0] e;
        logic [5:0] f;
    } fmt_t;

    // Fields after stage 1 (unpacked item)
    typedef struct packed {
        logic        sign;
        logic [7:0]  expf;
        logic [31:0] frac;   // fraction, left-justified at bit 31
        logic [5:0]  f;
        logic [3:0]  e;
    } fields_t;
endpackage

// File: sv/mf2d_cfg.sv
// APB register file holding and saturating the format settings
module mf2d_cfg #(
    parameter int PATTERN_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output mf2d_pkg::fmt_t        fmt
);
    import mf2d_pkg::*;

    logic [TW_W-1:0] tw_reg;
    logic [EW_W-1:0] ew_reg;
    logic            wr;
    logic [5:0]      t_sat;
    logic [3:0]      e_sat;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tw_reg <= TW_RESET;
            ew_reg <= EW_RESET;
        end else if (wr) begin
            if (paddr == ADDR_TOTAL_WIDTH) tw_reg <= pwdata[TW_W-1:0];
            if (paddr == ADDR_EXPONENT_WIDTH) ew_reg <= pwdata[EW_W-1:0];
        end
    end

    // read-back
    always_comb begin
        prdata = '0;
        case (paddr)
            ADDR_TOTAL_WIDTH:    prdata = {26'd0, tw_reg};
            ADDR_EXPONENT_WIDTH: prdata = {28'd0, ew_reg};
            default:             prdata = '0;
        endcase
    end

    // saturation into legal ranges
    always_comb begin
        t_sat = tw_reg;
        if (tw_reg < 6'd4) t_sat = 6'd4;
        if (tw_reg > 6'(PATTERN_BITS)) t_sat = 6'(PATTERN_BITS);
        e_sat = ew_reg;
        if (ew_reg < 4'd2) e_sat = 4'd2;
        if (ew_reg > 4'd8) e_sat = 4'd8;
        if (6'(e_sat) > t_sat - 6'd1) e_sat = 4'(t_sat - 6'd1);
        fmt.t = t_sat;
        fmt.e = e_sat;
        fmt.f = t_sat - 6'd1 - 6'(e_sat);
    end
endmodule

// File: sv/mf2d_unpack.sv
// Stage 1: field extraction of the raw pattern
module mf2d_unpack (
    input  logic [31:0]           pattern,
    input  mf2d_pkg::fmt_t        fmt,
    output mf2d_pkg::fields_t     fld
);
    import mf2d_pkg::*;

    logic [31:0] shr;
    logic [31:0] emask;

    always_comb begin
        shr   = pattern >> fmt.f;
        emask = (32'd1 << fmt.e) - 32'd1;
        fld.sign = pattern[5'(fmt.t - 6'd1)];
        fld.expf = 8'(shr & emask);
        // left-justify fraction: drop everything above it
        fld.frac = (fmt.f == 6'd0) ? 32'd0 : (pattern << (6'd32 - fmt.f));
        fld.f = fmt.f;
        fld.e = fmt.e;
    end
endmodule

// File: sv/mf2d_lzc.sv
// Leading-zero count over a 32-bit word
module mf2d_lzc (
    input  logic [31:0] din,
    output logic [5:0]  cnt
);
    logic [15:0] h;
    logic [7:0]  b;
    logic [3:0]  n;
    logic [1:0]  d;

    // binary search, five narrow steps
    always_comb begin
        cnt = 6'd0;
        if (din == 32'd0) begin
            cnt = 6'd32;
            h = '0; b = '0; n = '0; d = '0;
        end else begin
            if (din[31:16] == 16'd0) begin cnt[4] = 1'b1; h = din[15:0]; end
            else h = din[31:16];
            if (h[15:8] == 8'd0) begin cnt[3] = 1'b1; b = h[7:0]; end
            else b = h[15:8];
            if (b[7:4] == 4'd0) begin cnt[2] = 1'b1; n = b[3:0]; end
            else n = b[7:4];
            if (n[3:2] == 2'd0) begin cnt[1] = 1'b1; d = n[1:0]; end
            else d = n[3:2];
            cnt[0] = ~d[1];
        end
    end
endmodule

// File: sv/minifloat_to_binary64.sv
// Top level: three-stage minifloat to binary64 conversion pipeline
//  channel | dir | signals                     | payload
//  s_      | in  | s_tvalid s_tready s_tdata   | pattern[31:0]
//  m_      | out | m_tvalid m_tready m_tdata   | double_bits[63:0]
//  cfg     | in  | psel penable pwrite paddr   | total_width, exponent_width
// One request per cycle while m_tready does not stall; stages are unpack, leading-zero count, pack.
// Reset is synchronous and clears all valid bits and the registers to 16 and 5.
// A stall on m_tready holds the unbroken run of full stages at the output; s_tready falls only when the pipe is full.
module minifloat_to_binary64 #(
    parameter int PATTERN_BITS = mf2d_pkg::PATTERN_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] pattern
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] double_bits
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mf2d_pkg::*;

    fmt_t    fmt;
    fields_t fld;
    logic    adv1, adv2, adv3;

    logic    v1_reg, v2_reg, v3_reg;
    fields_t f1_reg;
    logic [5:0]  lz;
    logic [5:0]  lz2_reg;
    fields_t     f2_reg;
    logic [63:0] d3_reg, d3_next;

    mf2d_cfg #(.PATTERN_BITS(PATTERN_BITS)) u_cfg (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .fmt
    );

    mf2d_unpack u_unpack (.pattern(s_tdata), .fmt, .fld);

    // stage control: each stage moves when the one after it is free
    assign adv3 = !v3_reg || m_tready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign s_tready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_tvalid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    // stage 1: unpacked fields
    always_ff @(posedge aclk) begin
        if (adv1) f1_reg <= fld;
    end

    mf2d_lzc u_lzc (.din(f1_reg.frac), .cnt(lz));

    // stage 2: leading-zero count of the fraction
    always_ff @(posedge aclk) begin
        if (adv2) begin
            f2_reg  <= f1_reg;
            lz2_reg <= lz;
        end
    end

    // stage 3: exponent and mantissa assembly
    always_comb begin
        logic [10:0] bias;
        logic [10:0] dexp;
        logic [51:0] mant;
        logic [31:0] sh;
        bias = (11'd1 << (f2_reg.e - 4'd1)) - 11'd1;
        dexp = 11'd0;
        mant = 52'd0;
        sh   = 32'd0;
        if (f2_reg.expf != 8'd0) begin
            dexp = 11'(f2_reg.expf) - bias + 11'd1023;
            mant = {f2_reg.frac, 20'd0};
        end else if (f2_reg.frac != 32'd0) begin
            // msb = 31 - lz; dexp = 1023 - bias + msb - 31, relative to justified frac
            dexp = 11'd1023 - bias - 11'(lz2_reg);
            sh   = f2_reg.frac << (lz2_reg + 6'd1);
            mant = {sh, 20'd0};
        end
        d3_next = {f2_reg.sign, dexp, mant};
    end

    always_ff @(posedge aclk) begin
        if (adv3) d3_reg <= d3_next;
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = d3_reg;
endmodule

// File: sv/mf2d_checker.sv
// Port-level checker for the converter, bound to the top level
module mf2d_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        pready
);
`include "minifloat_to_binary64_assert.svh"
    `MF_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `MF_ASSERT_IMP(a_ready_when_free, !m_tvalid, s_tready)
    `MF_ASSERT_IMP(a_ready_follows, m_tready, s_tready)
    `MF_ASSERT_IMP(a_pready, 1'b1, pready)
endmodule

bind minifloat_to_binary64 mf2d_checker u_chk (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .pready
);
